[rtl/sso_pkg.sv]
// ============================================================================
// sso_pkg
// Shared types, constants and the sine table generator for the servo sine
// oscillator.
// ============================================================================
package sso_pkg;

    // Defaults for the top level parameters
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int TIME_WIDTH_DEF      = 32;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_MS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_AMPLITUDE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_DEG = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIM      = 3'd4;

    localparam logic [15:0]       PERIOD_RESET    = 16'd2000;
    localparam logic signed [8:0] AMPLITUDE_RESET = 9'sd50;

    // Request kinds (the fourth code acts as a refresh)
    localparam logic [1:0] KIND_REFRESH = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_LOAD    = 2'd2;

    // Degrees in a full turn, divisor of the phase conversion
    localparam logic [15:0] DEG_PER_TURN = 16'd360;

    // round(pi/2 * 2^30)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // (2k)(2k+1) for the Taylor terms k = 1..6
    localparam int unsigned TERM_DIV [6] = '{6, 20, 42, 72, 110, 156};

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
    } t_in_req;

    typedef struct packed {
        logic signed [18:0] position_q8;
        logic [31:0]        ref_time_out;
    } t_out_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHASE,
        ST_PHASE_END,
        ST_MOD,
        ST_MOD_END,
        ST_INDEX,
        ST_ROM,
        ST_MUL,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // take the request, update the reference
        logic ld_phase;  // load divider: |phase| * N / 360
        logic ld_mod;    // load divider: diff mod period
        logic clr_quo;   // start delta * N / period from the remainder
        logic step;      // one restoring division step
        logic save_ph;   // store the phase index
        logic rom_rd;    // read the quarter-wave table
        logic mul;       // amplitude * sine
        logic ld_out;    // load the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;  // output register full and stalled
    } t_dp_status;

    // sin(pi/2 * r/q) in Q15 with q = 2^(sb-2), for 0 <= r <= q.
    // Elaboration only.
    function automatic logic [14:0] quarter_sine(input int unsigned r, input int sb);
        logic [63:0]        theta;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        rnd;
        logic signed [63:0] sum;
        theta = ((64'(r) * HALF_PI_Q30) + (64'd1 << (sb - 3))) >> (sb - 2);
        t2    = (theta * theta) >> 30;
        term  = theta;
        sum   = signed'(theta);
        for (int k = 1; k <= 6; k++) begin
            term = ((term * t2) >> 30) / 64'(TERM_DIV[k-1]);
            if ((k % 2) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        rnd = (unsigned'(sum) + 64'd16384) >> 15;
        if (rnd > 64'd32767) begin
            rnd = 64'd32767;
        end
        return rnd[14:0];
    endfunction

endpackage

[rtl/sso_sine_rom.sv]
// ============================================================================
// sso_sine_rom
// Quarter-wave sine magnitude table, Q15, registered read.
// ============================================================================
module sso_sine_rom #(
    parameter int SINE_TABLE_BITS = sso_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rd,
    input  logic [SINE_TABLE_BITS-3:0] i_addr,
    input  logic                       i_peak,
    output logic [14:0]                o_mag
);
    import sso_pkg::*;

    localparam int QN = 1 << (SINE_TABLE_BITS - 2);
    localparam logic [14:0] PEAK = quarter_sine(QN, SINE_TABLE_BITS);

    logic [14:0] rom_data [QN];
    logic [14:0] r_mag;

    for (genvar g = 0; g < QN; g++) begin : g_rom
        assign rom_data[g] = quarter_sine(g, SINE_TABLE_BITS);
    end

    // quarter point (sin = 1) sits past the end of the table
    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_mag <= i_peak ? PEAK : rom_data[i_addr];
        end
    end

    assign o_mag = r_mag;

endmodule

[rtl/sso_datapath.sv]
// ============================================================================
// sso_datapath
// Settings, reference time, shared restoring divider, table lookup,
// multiply and output register.
// ============================================================================
module sso_datapath #(
    parameter int SINE_TABLE_BITS = sso_pkg::SINE_TABLE_BITS_DEF,
    parameter int TIME_WIDTH      = sso_pkg::TIME_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sso_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [sso_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  sso_pkg::t_in_req                    i_in_req,
    input  sso_pkg::t_dp_cmd                    i_cmd,
    output sso_pkg::t_dp_status                 o_status,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output sso_pkg::t_out_req                   o_out_req
);
    import sso_pkg::*;

    localparam int SB = SINE_TABLE_BITS;
    localparam int TW = TIME_WIDTH;
    localparam int DW = (TW > SB + 10) ? TW : SB + 10;

    // settings
    logic [15:0]        r_period_ms;
    logic signed [8:0]  r_amplitude;
    logic signed [9:0]  r_phase_deg;
    logic signed [8:0]  r_offset;
    logic signed [8:0]  r_trim;

    logic [TW-1:0]      r_ref;
    logic [TW-1:0]      r_diff;
    logic [TW-1:0]      w_now;
    logic               w_set_ref;

    // divider
    logic [DW-1:0]      r_dvd;
    logic [15:0]        r_rem;
    logic [15:0]        r_dvsr;
    logic [17:0]        w_trial;
    logic               w_ge;
    logic [9:0]         w_ph_abs;

    logic [SB-1:0]      r_ph_idx;
    logic [SB-1:0]      w_idx;
    logic [SB-3:0]      w_r;
    logic [SB-3:0]      w_addr;
    logic               w_peak;
    logic               r_neg;
    logic [14:0]        w_mag;

    logic signed [15:0] w_sine;
    logic signed [24:0] r_prod;
    logic signed [25:0] w_rnd;
    logic signed [18:0] w_pos;

    t_out_req           r_out;
    logic               r_out_valid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_ms <= PERIOD_RESET;
            r_amplitude <= AMPLITUDE_RESET;
            r_phase_deg <= '0;
            r_offset    <= '0;
            r_trim      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PERIOD_MS: r_period_ms <= i_cfg_data;
                CFG_AMPLITUDE: r_amplitude <= signed'(i_cfg_data[8:0]);
                CFG_PHASE_DEG: r_phase_deg <= signed'(i_cfg_data[9:0]);
                CFG_OFFSET:    r_offset    <= signed'(i_cfg_data[8:0]);
                CFG_TRIM:      r_trim      <= signed'(i_cfg_data[8:0]);
                default:       ;
            endcase
        end
    end

    // reference time; restart and load both give a zero delta
    assign w_now     = TW'(i_in_req.now_ms);
    assign w_set_ref = (i_in_req.kind == KIND_RESTART) || (i_in_req.kind == KIND_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= '0;
        end else if (i_cmd.capture && w_set_ref) begin
            r_ref <= w_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_diff <= w_set_ref ? '0 : (w_now - r_ref);
        end
    end

    // shared restoring divider, quotient shifts into the dividend register
    assign w_trial  = {1'b0, r_rem, r_dvd[DW-1]} - {2'b00, r_dvsr};
    assign w_ge     = !w_trial[17];
    assign w_ph_abs = r_phase_deg[9] ? 10'(-r_phase_deg) : 10'(r_phase_deg);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_phase) begin
            r_dvd  <= DW'({w_ph_abs, SB'(0)});
            r_rem  <= '0;
            r_dvsr <= DEG_PER_TURN;
        end else if (i_cmd.ld_mod) begin
            r_dvd  <= DW'(r_diff);
            r_rem  <= '0;
            r_dvsr <= (r_period_ms == '0) ? 16'd1 : r_period_ms;
        end else if (i_cmd.clr_quo) begin
            r_dvd  <= '0;
        end else if (i_cmd.step) begin
            r_dvd  <= {r_dvd[DW-2:0], w_ge};
            r_rem  <= w_ge ? w_trial[15:0] : {r_rem[14:0], r_dvd[DW-1]};
        end
    end

    // phase index, floored toward minus infinity, kept mod N
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_ph) begin
            if (r_phase_deg[9]) begin
                r_ph_idx <= SB'(0) - r_dvd[SB-1:0] - SB'(r_rem != '0);
            end else begin
                r_ph_idx <= r_dvd[SB-1:0];
            end
        end
    end

    // table index and quadrant folding
    assign w_idx  = r_dvd[SB-1:0] + r_ph_idx;
    assign w_r    = w_idx[SB-3:0];
    assign w_addr = w_idx[SB-2] ? (SB-2)'(-w_r) : w_r;
    assign w_peak = w_idx[SB-2] && (w_r == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rom_rd) begin
            r_neg <= w_idx[SB-1];
        end
    end

    sso_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_rom (
        .i_clk  (i_clk),
        .i_rd   (i_cmd.rom_rd),
        .i_addr (w_addr),
        .i_peak (w_peak),
        .o_mag  (w_mag)
    );

    assign w_sine = r_neg ? -signed'({1'b0, w_mag}) : signed'({1'b0, w_mag});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= 25'(r_amplitude * w_sine);
        end
    end

    // Q15 -> Q8 with rounding, then offset and trim
    assign w_rnd = (26'(r_prod) + 26'sd64) >>> 7;
    assign w_pos = 19'(w_rnd) + 19'((11'(r_offset) + 11'(r_trim)) * 19'sd256);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out.position_q8  <= w_pos;
            r_out.ref_time_out <= 32'(r_ref);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_req         = r_out;

endmodule

[rtl/sso_ctrl.sv]
// ============================================================================
// sso_ctrl
// Sequencer: phase division, mod division, index division, lookup,
// multiply, output.
// ============================================================================
module sso_ctrl #(
    parameter int SINE_TABLE_BITS = sso_pkg::SINE_TABLE_BITS_DEF,
    parameter int TIME_WIDTH      = sso_pkg::TIME_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sso_pkg::t_dp_status i_status,
    output sso_pkg::t_dp_cmd    o_cmd
);
    import sso_pkg::*;

    localparam int SB = SINE_TABLE_BITS;
    localparam int DW = (TIME_WIDTH > SB + 10) ? TIME_WIDTH : SB + 10;
    localparam int CW = $clog2(DW);

    t_state        r_state;
    t_state        n_state;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          w_accept;
    logic          w_last_wide;
    logic          w_last_idx;

    assign w_accept    = i_in_valid && (r_state == ST_IDLE);
    assign w_last_wide = (r_cnt == CW'(DW - 1));
    assign w_last_idx  = (r_cnt == CW'(SB - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (w_accept) n_state = ST_PHASE;
            ST_PHASE:     if (w_last_wide) n_state = ST_PHASE_END;
            ST_PHASE_END: n_state = ST_MOD;
            ST_MOD:       if (w_last_wide) n_state = ST_MOD_END;
            ST_MOD_END:   n_state = ST_INDEX;
            ST_INDEX:     if (w_last_idx) n_state = ST_ROM;
            ST_ROM:       n_state = ST_MUL;
            ST_MUL:       n_state = ST_OUT;
            ST_OUT:       if (!i_status.out_busy) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        n_cnt      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall     = 1'b0;
                o_cmd.capture  = w_accept;
                o_cmd.ld_phase = w_accept;
            end
            ST_PHASE: begin
                o_cmd.step = 1'b1;
                n_cnt      = w_last_wide ? '0 : r_cnt + 1'b1;
            end
            ST_PHASE_END: begin
                o_cmd.save_ph = 1'b1;
                o_cmd.ld_mod  = 1'b1;
            end
            ST_MOD: begin
                o_cmd.step = 1'b1;
                n_cnt      = w_last_wide ? '0 : r_cnt + 1'b1;
            end
            ST_MOD_END: begin
                o_cmd.clr_quo = 1'b1;
            end
            ST_INDEX: begin
                o_cmd.step = 1'b1;
                n_cnt      = w_last_idx ? '0 : r_cnt + 1'b1;
            end
            ST_ROM: begin
                o_cmd.rom_rd = 1'b1;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_OUT: begin
                o_cmd.ld_out = !i_status.out_busy;
            end
            default: ;
        endcase
    end

endmodule

[rtl/servo_sine_oscillator.sv]
// ============================================================================
// servo_sine_oscillator
// Servo gait sine oscillator: position = amplitude * sin(angle) + offset + trim
// in Q8, with the angle taken from the time since a kept reference.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_req): one request per update,
//   carrying the time in ms and a kind (refresh, restart the reference at that
//   time, or load the reference with that value).
//   Output channel (o_out_valid / i_out_stall / o_out_req): one result per
//   request: the Q8 position and the reference time after the request.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data): period, amplitude,
//   phase, offset and trim; write only while no request is in flight.
// Timing:
//   One shared restoring divider does three divisions per request:
//   |phase|*N/360 and diff mod period over D = max(TIME_WIDTH,
//   SINE_TABLE_BITS+10) steps each, then delta*N/period over SINE_TABLE_BITS
//   steps. The result is loaded into the output register after the table
//   lookup and the multiply. Requests are handled one at a time.
//   A new request is taken as soon as the previous result sits in the output
//   register, even while that result is stalled. If the output is still
//   stalled when the next result is ready, the sequencer waits on it.
// Reset:
//   Synchronous, active low. Reference time clears to zero, settings return
//   to period 2000, amplitude 50, others zero; output register empties.
// ============================================================================
module servo_sine_oscillator #(
    parameter int SINE_TABLE_BITS = sso_pkg::SINE_TABLE_BITS_DEF,
    parameter int TIME_WIDTH      = sso_pkg::TIME_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sso_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sso_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  sso_pkg::t_in_req                i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output sso_pkg::t_out_req               o_out_req
);
    import sso_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer: owns the step counter and the request handshake
    sso_ctrl #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .TIME_WIDTH      (TIME_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Datapath: settings, reference, divider, table, multiplier, output reg
    sso_datapath #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .TIME_WIDTH      (TIME_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_req    (i_in_req),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_req   (o_out_req)
    );

    // A taken request always starts the sequence, closing the input side
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not closed after a request was taken");

    // A result appears only from the busy sequence, never from idle
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result produced while sequencer idle");

    // Output loads only while the sequencer holds the input closed
    a_no_accept_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.ld_out) |-> o_in_stall)
        else $error("output loaded while input open");

endmodule
